>>> src/itrd_pkg.sv
// Shared types, constants and the digit-to-character map for the radix digit converter.
package itrd_pkg;

	localparam int VALUE_FIELD_BITS = 32;
	localparam int RADIX_BITS       = 6;
	localparam int DIGIT_BITS       = 6;
	localparam int CHAR_BITS        = 7;
	// quotient bits produced per divider cycle
	localparam int STEP_BITS        = 8;

	localparam logic [RADIX_BITS-1:0] RADIX_MIN  = 6'd2;
	localparam logic [RADIX_BITS-1:0] RADIX_MAX  = 6'd36;
	localparam logic [DIGIT_BITS-1:0] DEC_DIGITS = 6'd10;
	localparam logic [CHAR_BITS-1:0]  CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_BITS-1:0]  CHAR_A     = 7'h41;

	typedef struct packed {
		logic [VALUE_FIELD_BITS-1:0] value;
		logic [RADIX_BITS-1:0]       radix;
	} num_item_t;

	typedef struct packed {
		logic [CHAR_BITS-1:0] digit_char;
		logic                 last;
	} dig_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_STORE,
		ST_READ,
		ST_SHOW,
		ST_HOLD
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // capture a new number, clear counters
		logic step;   // one divider cycle
		logic store;  // write remainder digit, clear remainder
		logic adv;    // move digit pointer up
		logic read;   // read digit buffer at pointer
		logic show;   // load output register from read data
		logic back;   // move digit pointer down
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic chunk_last;
		logic quot_zero;
		logic ptr_zero;
	} sts_t;

	function automatic logic [CHAR_BITS-1:0] to_char(input logic [DIGIT_BITS-1:0] d);
		logic [DIGIT_BITS-1:0] off;
		off = d - DEC_DIGITS;
		if (d < DEC_DIGITS) begin
			return CHAR_ZERO + CHAR_BITS'(d);
		end
		return CHAR_A + CHAR_BITS'(off);
	endfunction

endpackage

>>> src/itrd_dp.sv
// Datapath: radix divider, digit buffer, pointers and output register.
module itrd_dp #(
	parameter int VALUE_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  itrd_pkg::num_item_t       num,
	input  itrd_pkg::cmd_t            cmd,
	output itrd_pkg::sts_t            sts,
	output itrd_pkg::dig_item_t       dig
);

	localparam int SB = itrd_pkg::STEP_BITS;
	localparam int PW = ((VALUE_BITS + SB - 1) / SB) * SB;
	localparam int CH = PW / SB;
	localparam int CW = (CH > 1) ? $clog2(CH) : 1;
	localparam int AW = $clog2(VALUE_BITS);
	localparam int DB = itrd_pkg::DIGIT_BITS;

	logic [PW-1:0]                      val_q;
	logic [DB-1:0]                      rem_q;
	logic [itrd_pkg::RADIX_BITS-1:0]    radix_q;
	logic [CW-1:0]                      chunk_q;
	logic [AW-1:0]                      ptr_q;
	logic [DB-1:0]                      rd_q;
	itrd_pkg::dig_item_t                dig_q;
	logic [DB-1:0]                      mem [VALUE_BITS];

	logic [63:0]                        v_ext;
	logic [PW-1:0]                      v_load;
	logic [itrd_pkg::RADIX_BITS-1:0]    r_sat;
	logic [SB-1:0]                      qbits;
	logic [DB-1:0]                      rem_d;

	// input value cut to the working width, radix clamped into range
	always_comb begin
		v_ext  = 64'(num.value);
		v_load = PW'(v_ext[VALUE_BITS-1:0]);
		if (num.radix < itrd_pkg::RADIX_MIN) begin
			r_sat = itrd_pkg::RADIX_MIN;
		end else if (num.radix > itrd_pkg::RADIX_MAX) begin
			r_sat = itrd_pkg::RADIX_MAX;
		end else begin
			r_sat = num.radix;
		end
	end

	// restoring division, SB quotient bits per cycle; remainder stays below radix
	always_comb begin
		logic [DB-1:0] r;
		logic [DB:0]   t;
		r = rem_q;
		qbits = '0;
		for (int i = 0; i < SB; i++) begin
			t = {r, val_q[PW-1-i]};
			if (t >= {1'b0, radix_q}) begin
				t = t - {1'b0, radix_q};
				qbits[SB-1-i] = 1'b1;
			end
			r = t[DB-1:0];
		end
		rem_d = r;
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= '0;
			ptr_q   <= '0;
		end else begin
			if (cmd.load || cmd.store) begin
				chunk_q <= '0;
			end else if (cmd.step) begin
				chunk_q <= chunk_q + 1'b1;
			end
			if (cmd.load) begin
				ptr_q <= '0;
			end else if (cmd.adv) begin
				ptr_q <= ptr_q + 1'b1;
			end else if (cmd.back) begin
				ptr_q <= ptr_q - 1'b1;
			end
		end
	end

	// working value, remainder and radix
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q   <= v_load;
			rem_q   <= '0;
			radix_q <= r_sat;
		end else if (cmd.step) begin
			val_q <= (val_q << SB) | PW'(qbits);
			rem_q <= rem_d;
		end else if (cmd.store) begin
			rem_q <= '0;
		end
	end

	// digit buffer, least significant digit at index zero
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[ptr_q] <= rem_q;
		end
		if (cmd.read) begin
			rd_q <= mem[ptr_q];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.show) begin
			dig_q.digit_char <= itrd_pkg::to_char(rd_q);
			dig_q.last       <= (ptr_q == '0);
		end
	end

	assign dig            = dig_q;
	assign sts.chunk_last = (chunk_q == CW'(CH - 1));
	assign sts.quot_zero  = (val_q == '0);
	assign sts.ptr_zero   = (ptr_q == '0);

endmodule

>>> src/itrd_ctrl.sv
// Controller: sequences divide, store and emit phases for one number.
module itrd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            num_valid,
	output logic            num_stall,
	output logic            dig_valid,
	input  logic            dig_stall,
	input  itrd_pkg::sts_t  sts,
	output itrd_pkg::cmd_t  cmd
);

	itrd_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itrd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		num_stall = 1'b1;
		dig_valid = 1'b0;
		case (state_q)
			itrd_pkg::ST_IDLE: begin
				num_stall = 1'b0;
				if (num_valid) begin
					cmd.load = 1'b1;
					state_d  = itrd_pkg::ST_DIV;
				end
			end
			itrd_pkg::ST_DIV: begin
				cmd.step = 1'b1;
				if (sts.chunk_last) begin
					state_d = itrd_pkg::ST_STORE;
				end
			end
			itrd_pkg::ST_STORE: begin
				cmd.store = 1'b1;
				if (sts.quot_zero) begin
					state_d = itrd_pkg::ST_READ;
				end else begin
					cmd.adv = 1'b1;
					state_d = itrd_pkg::ST_DIV;
				end
			end
			itrd_pkg::ST_READ: begin
				cmd.read = 1'b1;
				state_d  = itrd_pkg::ST_SHOW;
			end
			itrd_pkg::ST_SHOW: begin
				cmd.show = 1'b1;
				state_d  = itrd_pkg::ST_HOLD;
			end
			itrd_pkg::ST_HOLD: begin
				dig_valid = 1'b1;
				if (!dig_stall) begin
					if (sts.ptr_zero) begin
						state_d = itrd_pkg::ST_IDLE;
					end else begin
						cmd.back = 1'b1;
						state_d  = itrd_pkg::ST_READ;
					end
				end
			end
			default: begin
				state_d = itrd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> src/integer_to_radix_digits.sv
// Top level of the integer to radix digit converter.
//
//  channel  dir  handshake             payload
//  num      in   num_valid/num_stall   value[31:0], radix[5:0]
//  dig      out  dig_valid/dig_stall   digit_char[6:0], last
//
// One number is taken while idle; its digits follow most significant first.
// Each digit takes CH division steps (CH = VALUE_BITS/8 rounded up), one 8-bit
// quotient slice per cycle, and a store step; the digits are then read from the
// digit buffer and presented through the read, show and hold states.
// Reset clears the controller and the pointers; the digit buffer needs no clearing.
// A stalled digit holds its payload; num_stall stays high until the last digit leaves.
module integer_to_radix_digits #(
	parameter int VALUE_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 num_valid,
	output logic                 num_stall,
	input  itrd_pkg::num_item_t  num,
	output logic                 dig_valid,
	input  logic                 dig_stall,
	output itrd_pkg::dig_item_t  dig
);

	itrd_pkg::cmd_t cmd;
	itrd_pkg::sts_t sts;

	itrd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_valid (num_valid),
		.num_stall (num_stall),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	itrd_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num),
		.cmd    (cmd),
		.sts    (sts),
		.dig    (dig)
	);

endmodule

>>> src/itrd_check.sv
// Port-level checker for the radix digit converter, bound to the top level.
module itrd_check (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 num_valid,
	input logic                 num_stall,
	input logic                 dig_valid,
	input logic                 dig_stall,
	input itrd_pkg::dig_item_t  dig
);

	// a stalled digit stays up and unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig_stall |=> dig_valid && $stable(dig))
		else $error("stalled digit changed or dropped");

	// a number is only taken when no digit is pending
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!num_stall |-> !dig_valid)
		else $error("input open while a digit is pending");

	// the block goes busy right after taking a number
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		num_valid && !num_stall |=> num_stall)
		else $error("second number taken without conversion");

	// digits are legal characters
	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> (dig.digit_char >= 7'h30 && dig.digit_char <= 7'h39) ||
		              (dig.digit_char >= 7'h41 && dig.digit_char <= 7'h5A))
		else $error("digit character out of range");

	// dig_valid is low in the cycle after each delivered digit
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_stall |=> !dig_valid)
		else $error("digit repeated without a buffer read");

endmodule

bind integer_to_radix_digits itrd_check u_itrd_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.num_valid (num_valid),
	.num_stall (num_stall),
	.dig_valid (dig_valid),
	.dig_stall (dig_stall),
	.dig       (dig)
);

>>> test/tb_integer_to_radix_digits.sv
// Self-checking testbench for the integer to radix digit converter.
module tb_integer_to_radix_digits;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VALUE_BITS = 32;
	localparam logic [itrd_pkg::VALUE_FIELD_BITS-1:0] VALUE_MASK =
		{itrd_pkg::VALUE_FIELD_BITS{1'b1}} >> (itrd_pkg::VALUE_FIELD_BITS - VALUE_BITS);
	// long enough for the longest number to finish
	localparam int SETTLE_CYCLES = 300;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                num_valid = 1'b0;
	logic                num_stall;
	itrd_pkg::num_item_t num = '0;
	logic                dig_valid;
	logic                dig_stall = 1'b0;
	itrd_pkg::dig_item_t dig;

	itrd_pkg::dig_item_t digits_due[$];
	int                  fail_count = 0;
	int                  tx_idle_pct = 0;
	int                  rx_idle_pct = 0;
	int                  rx_hold_left = 0;

	integer_to_radix_digits #(
		.VALUE_BITS(VALUE_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.num_valid(num_valid),
		.num_stall(num_stall),
		.num      (num),
		.dig_valid(dig_valid),
		.dig_stall(dig_stall),
		.dig      (dig)
	);

	always #5 clk = ~clk;

	// Digits of one number, most significant first, appended to the due list
	function automatic void queue_radix_digits(input itrd_pkg::num_item_t item);
		logic [itrd_pkg::VALUE_FIELD_BITS-1:0] rest;
		logic [itrd_pkg::RADIX_BITS-1:0]       base;
		logic [itrd_pkg::DIGIT_BITS-1:0]       rev[$];
		itrd_pkg::dig_item_t                   d;
		rest = item.value & VALUE_MASK;
		base = item.radix;
		if (base < itrd_pkg::RADIX_MIN) begin
			base = itrd_pkg::RADIX_MIN;
		end else if (base > itrd_pkg::RADIX_MAX) begin
			base = itrd_pkg::RADIX_MAX;
		end
		// zero still yields one digit
		do begin
			rev.push_front(itrd_pkg::DIGIT_BITS'(rest % base));
			rest = rest / base;
		end while (rest != 0);
		foreach (rev[k]) begin
			if (rev[k] < itrd_pkg::DEC_DIGITS) begin
				d.digit_char = itrd_pkg::CHAR_ZERO + itrd_pkg::CHAR_BITS'(rev[k]);
			end else begin
				d.digit_char = itrd_pkg::CHAR_A +
					itrd_pkg::CHAR_BITS'(rev[k] - itrd_pkg::DEC_DIGITS);
			end
			d.last = (k == rev.size() - 1);
			digits_due.push_back(d);
		end
	endfunction

	function automatic itrd_pkg::num_item_t num_of(input logic [31:0] v,
		input logic [5:0] r);
		itrd_pkg::num_item_t it;
		it.value = v;
		it.radix = r;
		return it;
	endfunction

	function automatic itrd_pkg::num_item_t random_number();
		itrd_pkg::num_item_t it;
		case ($urandom_range(9))
			0: it.value = '0;
			1: it.value = '1;
			2, 3, 4: it.value = $urandom >> $urandom_range(31);
			default: it.value = $urandom;
		endcase
		case ($urandom_range(9))
			0: it.radix = itrd_pkg::RADIX_BITS'($urandom_range(63));
			1: it.radix = itrd_pkg::RADIX_MIN;
			default: it.radix = itrd_pkg::RADIX_BITS'(
				$urandom_range(itrd_pkg::RADIX_MAX, itrd_pkg::RADIX_MIN));
		endcase
		return it;
	endfunction

	// Offer one number, idling first at random; valid stays high after acceptance
	task automatic send_number(input itrd_pkg::num_item_t item);
		while ($urandom_range(99) < tx_idle_pct) begin
			num_valid <= 1'b0;
			@(posedge clk);
		end
		num_valid <= 1'b1;
		num <= item;
		do @(posedge clk); while (num_stall);
		queue_radix_digits(item);
	endtask

	// Sender pauses until every due digit has come out
	task automatic wait_drained();
		num_valid <= 1'b0;
		do @(posedge clk); while (digits_due.size() != 0);
	endtask

	// Receiver stall: a long hold when requested, else random
	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			dig_stall <= 1'b1;
			rx_hold_left = rx_hold_left - 1;
		end else begin
			dig_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Compare each accepted digit with the oldest due one
	always @(posedge clk) begin : digit_check
		itrd_pkg::dig_item_t due;
		if (arst_n && dig_valid && !dig_stall) begin
			if (digits_due.size() == 0) begin
				$error("digit with nothing due: digit_char %0d last %0b",
					dig.digit_char, dig.last);
				fail_count++;
			end else begin
				due = digits_due.pop_front();
				if (dig.digit_char !== due.digit_char) begin
					$error("digit_char: expected %0d, got %0d", due.digit_char, dig.digit_char);
					fail_count++;
				end
				if (dig.last !== due.last) begin
					$error("last: expected %0b, got %0b", due.last, dig.last);
					fail_count++;
				end
			end
		end
	end

	task automatic test_zero_value();
		send_number(num_of(32'd0, 6'd10));
		send_number(num_of(32'd0, 6'd2));
		send_number(num_of(32'd0, 6'd36));
		wait_drained();
	endtask

	task automatic test_radix_saturation();
		send_number(num_of(32'd1000, 6'd0));
		send_number(num_of(32'd1000, 6'd1));
		send_number(num_of(32'd1000, 6'd37));
		send_number(num_of(32'hDEADBEEF, 6'd63));
		send_number(num_of(32'd0, 6'd63));
		wait_drained();
	endtask

	task automatic test_extreme_values();
		send_number(num_of(32'hFFFFFFFF, 6'd2));
		send_number(num_of(32'h80000000, 6'd2));
		send_number(num_of(32'hFFFFFFFF, 6'd36));
		send_number(num_of(32'hFFFFFFFF, 6'd16));
		send_number(num_of(32'hAAAAAAAA, 6'd3));
		send_number(num_of(32'h55555555, 6'd7));
		send_number(num_of(32'd1, 6'd2));
		send_number(num_of(32'd9, 6'd10));
		send_number(num_of(32'd10, 6'd16));
		send_number(num_of(32'd35, 6'd36));
		send_number(num_of(32'd36, 6'd36));
		send_number(num_of(32'd12345, 6'd10));
		send_number(num_of(32'd4294967, 6'd35));
		wait_drained();
	endtask

	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (count) send_number(random_number());
		wait_drained();
	endtask

	// Hold the output long enough that the input backs up
	task automatic test_output_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_left = 600;
		repeat (16) send_number(random_number());
		wait_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_value();
		test_radix_saturation();
		test_extreme_values();
		test_random_traffic(9, 87, 105);
		test_random_traffic(87, 9, 105);
		test_random_traffic(0, 0, 105);
		test_output_backpressure();
		rx_idle_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (digits_due.size() != 0) begin
			$error("%0d digits never arrived", digits_due.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Run limit
	initial begin
		#10ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
